### sv/pda_pkg.sv
// Shared constants, types and helpers of the polar dye advection block.
// No dependencies; imported by pda_div, polar_dye_advection and the testbench.
package pda_pkg;

   // Grid limits and fixed-point format
   localparam int MAX_ANGLE_CELLS  = 256;
   localparam int MAX_RADIUS_CELLS = 128;
   localparam int FRAC_BITS        = 8;
   localparam int FIELD_CELLS      = MAX_ANGLE_CELLS * MAX_RADIUS_CELLS;
   localparam int ADDR_W           = $clog2(FIELD_CELLS);
   localparam int MIN_ANGLE_CELLS  = 8;
   localparam int MIN_RADIUS_CELLS = 4;

   // Divider geometry: w0*rc*rc needs 25 bits, r*r needs 14
   localparam int DIV_DVD_W = 25;
   localparam int DIV_DVS_W = 14;
   localparam int DIV_CNT_W = $clog2(DIV_DVD_W + 1);

   // Command codes
   localparam logic [1:0] CMD_ADVECT = 2'd0;
   localparam logic [1:0] CMD_INJECT = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_ANGLE_CELLS  = 2'd0;
   localparam logic [1:0] REG_RADIUS_CELLS = 2'd1;
   localparam logic [1:0] REG_FADE_STEP    = 2'd2;

   // Register reset values
   localparam logic [8:0] ANGLE_CELLS_RST  = 9'd256;
   localparam logic [7:0] RADIUS_CELLS_RST = 8'd128;
   localparam logic [7:0] FADE_STEP_RST    = 8'd2;

   // Divider result back to the controller
   typedef struct packed {
      logic                 done;
      logic [DIV_DVD_W-1:0] quot;
   } div_rsp_type;

   // Controller states
   typedef enum logic [19:0] {
      S_CLEAR    = 20'h00001,
      S_IDLE     = 20'h00002,
      S_ACCESS   = 20'h00004,
      S_ROW_MUL  = 20'h00008,
      S_ROW_MUL2 = 20'h00010,
      S_OM_GO    = 20'h00020,
      S_DIV_OM   = 20'h00040,
      S_DR_GO    = 20'h00080,
      S_DIV_DR   = 20'h00100,
      S_ROW_BASE = 20'h00200,
      S_PREP     = 20'h00400,
      S_RD0      = 20'h00800,
      S_RD1      = 20'h01000,
      S_RD2      = 20'h02000,
      S_RD3      = 20'h04000,
      S_LAST     = 20'h08000,
      S_LERP     = 20'h10000,
      S_OUT      = 20'h20000,
      S_COPY     = 20'h40000,
      S_FINISH   = 20'h80000
   } state_type;

   // lo + floor((hi - lo) * frac / 2^FRAC_BITS); stays between lo and hi
   function automatic logic [7:0] lerp8(input logic [7:0] lo, input logic [7:0] hi,
                                        input logic [7:0] frac);
      logic signed [8:0]  diff;
      logic signed [17:0] prod;
      logic signed [9:0]  sum;
      diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
      prod = diff * $signed({1'b0, frac});
      sum  = $signed({2'b00, lo}) + $signed(prod[17:FRAC_BITS]);
      return sum[7:0];
   endfunction

endpackage

### sv/pda_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pda_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/pda_div.sv
// Restoring divider, one quotient bit per cycle, for the per-row motion terms.
// Depends on pda_pkg.
module pda_div import pda_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_DVD_W-1:0] dividend,
   input  logic [DIV_DVS_W-1:0] divisor,
   output div_rsp_type          rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_DVD_W-1:0] quo_ff, quo_in;
   logic [DIV_DVS_W-1:0] rem_ff, rem_in;
   logic [DIV_DVS_W-1:0] dvs_ff, dvs_in;
   logic [DIV_DVS_W:0]   rem_sh;

   // One shift-subtract step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, quo_ff[DIV_DVD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_DVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = DIV_DVS_W'(rem_sh - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIV_DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIV_DVS_W-1:0];
            quo_in = {quo_ff[DIV_DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

### sv/polar_dye_advection.sv
// Polar dye advection block: the two field memories, the row divider and
// the controller that sequences advect, inject and read commands.
// Depends on pda_pkg, pda_ram and pda_div.
//
// Usage:
// Commands arrive as beats on the req_ stream; every command returns exactly
// one 8-bit beat on the rsp_ stream (the cell for a read, zero otherwise).
// The user is to write angle_cells, radius_cells and fade_step over the csr_
// port only while idle; the block itself does not enforce this.
// Commands are handled one at a time. Read and inject pass through the access
// and finish states before the response beat. Advect runs per row: multiply
// steps and one or two 25-step divisions, then per cell column setup, four
// reads from the single read port of the dye memory, two interpolation
// stages and one write to the scratch field; then a copy back of
// angle*radius cells, one a cycle.
// After reset the block clears all 32768 cells of the dye memory, one cell a
// cycle, with req_tready low; csr writes are taken throughout.
// The response sits in an output register, so a new command is accepted
// while the previous beat waits; a stalled receiver only holds the
// controller once the next response is ready.
module polar_dye_advection import pda_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // cmd, core_rate, outward_rate, core_radius, angle_index, radius_index,
   // dye_value from bit 0 up; bits 55:53 zero
   input  logic [55:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cell_value
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [8:0] ang_cells_ff;
   logic [7:0] rad_cells_ff;
   logic [7:0] fade_ff;

   logic [1:0]  cmd_ff, cmd_in;
   logic [10:0] w0_ff, w0_in;
   logic [9:0]  v0_ff, v0_in;
   logic [6:0]  rc_ff, rc_in;
   logic [7:0]  dv_ff, dv_in;
   logic        inside_ff, inside_in;
   logic [ADDR_W-1:0] acc_addr_ff, acc_addr_in;

   logic [6:0]  r_ff, r_in;
   logic [7:0]  a_ff, a_in;
   logic [17:0] prod1_ff, prod1_in;
   logic [24:0] prod2_ff, prod2_in;
   logic [13:0] rsq_ff, rsq_in;
   logic [16:0] dvd2_ff, dvd2_in;
   logic [7:0]  dvs2_ff, dvs2_in;
   logic [10:0] om_ff, om_in;
   logic [9:0]  dr_ff, dr_in;
   logic [ADDR_W-1:0] base0_ff, base0_in, base1_ff, base1_in;
   logic [7:0]  rf_ff, rf_in;
   logic [7:0]  a0_ff, a0_in, a1_ff, a1_in, af_ff, af_in;
   logic [7:0]  d00_ff, d00_in, d01_ff, d01_in, d10_ff, d10_in, d11_ff, d11_in;
   logic [7:0]  top_ff, top_in, bot_ff, bot_in;
   logic [ADDR_W:0] idx_ff, idx_in, cp_ff, cp_in;
   logic        cpv_ff, cpv_in;
   logic [ADDR_W-1:0] cpa_ff, cpa_in, clr_ff, clr_in;
   logic [7:0]  res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;

   // Memory and divider hookup
   logic              dye_we, nxt_we;
   logic [ADDR_W-1:0] dye_waddr, dye_raddr, nxt_waddr, nxt_raddr;
   logic [7:0]        dye_wdata, dye_rdata, nxt_wdata, nxt_rdata;
   logic              div_start;
   logic [DIV_DVD_W-1:0] div_dvd;
   logic [DIV_DVS_W-1:0] div_dvs;
   div_rsp_type       div_rsp;

   // Field views of the request beat
   logic [1:0]  req_cmd;
   logic [10:0] req_core_rate;
   logic [9:0]  req_outward_rate;
   logic [6:0]  req_core_radius;
   logic [7:0]  req_angle_index;
   logic [6:0]  req_radius_index;
   logic [7:0]  req_dye_value;

   assign req_cmd          = req_tdata[1:0];
   assign req_core_rate    = req_tdata[12:2];
   assign req_outward_rate = req_tdata[22:13];
   assign req_core_radius  = req_tdata[29:23];
   assign req_angle_index  = req_tdata[37:30];
   assign req_radius_index = req_tdata[44:38];
   assign req_dye_value    = req_tdata[52:45];

   // Effective grid size
   logic [8:0] na;
   logic [7:0] nr, nr_m1;

   always_comb begin
      if (ang_cells_ff < 9'(MIN_ANGLE_CELLS)) begin
         na = 9'(MIN_ANGLE_CELLS);
      end else if (ang_cells_ff > 9'(MAX_ANGLE_CELLS)) begin
         na = 9'(MAX_ANGLE_CELLS);
      end else begin
         na = ang_cells_ff;
      end
      if (rad_cells_ff < 8'(MIN_RADIUS_CELLS)) begin
         nr = 8'(MIN_RADIUS_CELLS);
      end else if (rad_cells_ff > 8'(MAX_RADIUS_CELLS)) begin
         nr = 8'(MAX_RADIUS_CELLS);
      end else begin
         nr = rad_cells_ff;
      end
      nr_m1 = nr - 8'd1;
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ang_cells_ff <= ANGLE_CELLS_RST;
         rad_cells_ff <= RADIUS_CELLS_RST;
         fade_ff      <= FADE_STEP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ANGLE_CELLS:  ang_cells_ff <= csr_wdata;
            REG_RADIUS_CELLS: rad_cells_ff <= csr_wdata[7:0];
            REG_FADE_STEP:    fade_ff      <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Row setup arithmetic
   logic signed [16:0] rq;
   logic signed [8:0]  r0s, r1s;
   logic [6:0]         r0c, r1c;
   // Cell setup arithmetic
   logic signed [17:0] aq;
   logic signed [9:0]  a0s, a1s, a0t, a1t;
   // Output stage
   logic [7:0] samp, faded;
   logic       last_a, last_r;
   logic [15:0] acc_prod;

   always_comb begin
      rq  = $signed({2'b00, r_ff, 8'b0}) - $signed({7'b0, dr_ff});
      r0s = rq[16:FRAC_BITS];
      r1s = r0s + 9'sd1;
      if (r0s < 0) begin
         r0c = '0;
      end else if (r0s > $signed({1'b0, nr_m1})) begin
         r0c = nr_m1[6:0];
      end else begin
         r0c = r0s[6:0];
      end
      if (r1s < 0) begin
         r1c = '0;
      end else if (r1s > $signed({1'b0, nr_m1})) begin
         r1c = nr_m1[6:0];
      end else begin
         r1c = r1s[6:0];
      end

      aq  = $signed({2'b00, a_ff, 8'b0}) - $signed({7'b0, om_ff});
      a0s = aq[17:FRAC_BITS];
      a1s = a0s + 10'sd1;
      a0t = a0s + $signed({1'b0, na});
      a1t = a1s + $signed({1'b0, na});

      samp   = lerp8(top_ff, bot_ff, rf_ff);
      faded  = (samp > fade_ff) ? samp - fade_ff : 8'd0;
      last_a = ({1'b0, a_ff} == na - 9'd1);
      last_r = ({1'b0, r_ff} == nr_m1);
      acc_prod = 16'(req_radius_index) * 16'(na) + 16'(req_angle_index);
   end

   // Controller
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      w0_in        = w0_ff;
      v0_in        = v0_ff;
      rc_in        = rc_ff;
      dv_in        = dv_ff;
      inside_in    = inside_ff;
      acc_addr_in  = acc_addr_ff;
      r_in         = r_ff;
      a_in         = a_ff;
      prod1_in     = prod1_ff;
      prod2_in     = prod2_ff;
      rsq_in       = rsq_ff;
      dvd2_in      = dvd2_ff;
      dvs2_in      = dvs2_ff;
      om_in        = om_ff;
      dr_in        = dr_ff;
      base0_in     = base0_ff;
      base1_in     = base1_ff;
      rf_in        = rf_ff;
      a0_in        = a0_ff;
      a1_in        = a1_ff;
      af_in        = af_ff;
      d00_in       = d00_ff;
      d01_in       = d01_ff;
      d10_in       = d10_ff;
      d11_in       = d11_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      idx_in       = idx_ff;
      cp_in        = cp_ff;
      cpv_in       = 1'b0;
      cpa_in       = cpa_ff;
      clr_in       = clr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      dye_we       = 1'b0;
      dye_waddr    = cpa_ff;
      dye_wdata    = nxt_rdata;
      dye_raddr    = acc_addr_ff;
      nxt_we       = 1'b0;
      nxt_waddr    = idx_ff[ADDR_W-1:0];
      nxt_wdata    = faded;
      nxt_raddr    = cp_ff[ADDR_W-1:0];
      div_start    = 1'b0;
      div_dvd      = 25'(prod2_ff);
      div_dvs      = rsq_ff;

      unique case (state_ff)
         // Zero the dye memory after reset
         S_CLEAR: begin
            dye_we    = 1'b1;
            dye_waddr = clr_ff;
            dye_wdata = 8'd0;
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            dye_raddr  = acc_prod[ADDR_W-1:0];
            if (req_tvalid) begin
               cmd_in      = req_cmd;
               w0_in       = req_core_rate;
               v0_in       = req_outward_rate;
               rc_in       = req_core_radius;
               dv_in       = req_dye_value;
               inside_in   = ({1'b0, req_angle_index} < na) &&
                             ({1'b0, req_radius_index} < nr);
               acc_addr_in = acc_prod[ADDR_W-1:0];
               res_in      = 8'd0;
               priority if (req_cmd == CMD_ADVECT) begin
                  r_in     = '0;
                  idx_in   = '0;
                  state_in = S_ROW_MUL;
               end else if (req_cmd == CMD_INJECT || req_cmd == CMD_READ) begin
                  state_in = S_ACCESS;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         // Cell data is back: read returns it, inject keeps the larger
         S_ACCESS: begin
            if (cmd_ff == CMD_READ) begin
               res_in = inside_ff ? dye_rdata : 8'd0;
            end else if (inside_ff && dv_ff > dye_rdata) begin
               dye_we    = 1'b1;
               dye_waddr = acc_addr_ff;
               dye_wdata = dv_ff;
            end
            state_in = S_FINISH;
         end
         // Per-row motion terms
         S_ROW_MUL: begin
            prod1_in = 18'(w0_ff) * 18'(rc_ff);
            rsq_in   = 14'(r_ff) * 14'(r_ff);
            dvd2_in  = 17'(v0_ff) * 17'({1'b0, rc_ff} + 8'd1);
            dvs2_in  = 8'(r_ff) + 8'(rc_ff) + 8'd1;
            state_in = S_ROW_MUL2;
         end
         S_ROW_MUL2: begin
            prod2_in = 25'(prod1_ff) * 25'(rc_ff);
            state_in = S_OM_GO;
         end
         S_OM_GO: begin
            if (r_ff > rc_ff) begin
               div_start = 1'b1;
               state_in  = S_DIV_OM;
            end else begin
               om_in    = w0_ff;
               state_in = S_DR_GO;
            end
         end
         S_DIV_OM: begin
            if (div_rsp.done) begin
               om_in    = div_rsp.quot[10:0];
               state_in = S_DR_GO;
            end
         end
         S_DR_GO: begin
            div_start = 1'b1;
            div_dvd   = 25'(dvd2_ff);
            div_dvs   = 14'(dvs2_ff);
            state_in  = S_DIV_DR;
         end
         S_DIV_DR: begin
            if (div_rsp.done) begin
               dr_in    = div_rsp.quot[9:0];
               state_in = S_ROW_BASE;
            end
         end
         // Source rows, clamped, and their base addresses
         S_ROW_BASE: begin
            rf_in    = rq[FRAC_BITS-1:0];
            base0_in = ADDR_W'(16'(r0c) * 16'(na));
            base1_in = ADDR_W'(16'(r1c) * 16'(na));
            a_in     = '0;
            state_in = S_PREP;
         end
         // Source columns with wrap-around
         S_PREP: begin
            af_in = aq[FRAC_BITS-1:0];
            a0_in = (a0s < 0) ? a0t[7:0] : a0s[7:0];
            priority if (a1s < 0) begin
               a1_in = a1t[7:0];
            end else if (a1s == $signed({1'b0, na})) begin
               a1_in = 8'd0;
            end else begin
               a1_in = a1s[7:0];
            end
            state_in = S_RD0;
         end
         // Four corner reads, each one's data arriving in the next state
         S_RD0: begin
            dye_raddr = base0_ff + ADDR_W'(a0_ff);
            state_in  = S_RD1;
         end
         S_RD1: begin
            dye_raddr = base0_ff + ADDR_W'(a1_ff);
            d00_in    = dye_rdata;
            state_in  = S_RD2;
         end
         S_RD2: begin
            dye_raddr = base1_ff + ADDR_W'(a0_ff);
            d01_in    = dye_rdata;
            state_in  = S_RD3;
         end
         S_RD3: begin
            dye_raddr = base1_ff + ADDR_W'(a1_ff);
            d10_in    = dye_rdata;
            state_in  = S_LAST;
         end
         S_LAST: begin
            d11_in   = dye_rdata;
            state_in = S_LERP;
         end
         S_LERP: begin
            top_in   = lerp8(d00_ff, d01_ff, af_ff);
            bot_in   = lerp8(d10_ff, d11_ff, af_ff);
            state_in = S_OUT;
         end
         // Radial blend, fade, store to the scratch field
         S_OUT: begin
            nxt_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (last_a) begin
               if (last_r) begin
                  cp_in    = '0;
                  state_in = S_COPY;
               end else begin
                  r_in     = r_ff + 1'b1;
                  state_in = S_ROW_MUL;
               end
            end else begin
               a_in     = a_ff + 1'b1;
               state_in = S_PREP;
            end
         end
         // Copy the scratch field back, one cell a cycle
         S_COPY: begin
            dye_we = cpv_ff;
            if (cp_ff < idx_ff) begin
               cp_in  = cp_ff + 1'b1;
               cpv_in = 1'b1;
               cpa_in = cp_ff[ADDR_W-1:0];
            end else if (!cpv_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cpv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cpv_ff       <= cpv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      w0_ff       <= w0_in;
      v0_ff       <= v0_in;
      rc_ff       <= rc_in;
      dv_ff       <= dv_in;
      inside_ff   <= inside_in;
      acc_addr_ff <= acc_addr_in;
      r_ff        <= r_in;
      a_ff        <= a_in;
      prod1_ff    <= prod1_in;
      prod2_ff    <= prod2_in;
      rsq_ff      <= rsq_in;
      dvd2_ff     <= dvd2_in;
      dvs2_ff     <= dvs2_in;
      om_ff       <= om_in;
      dr_ff       <= dr_in;
      base0_ff    <= base0_in;
      base1_ff    <= base1_in;
      rf_ff       <= rf_in;
      a0_ff       <= a0_in;
      a1_ff       <= a1_in;
      af_ff       <= af_in;
      d00_ff      <= d00_in;
      d01_ff      <= d01_in;
      d10_ff      <= d10_in;
      d11_ff      <= d11_in;
      top_ff      <= top_in;
      bot_ff      <= bot_in;
      idx_ff      <= idx_in;
      cp_ff       <= cp_in;
      cpa_ff      <= cpa_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Live dye field
   pda_ram #(.WIDTH(8), .DEPTH(FIELD_CELLS)) u_dye_ram (
      .clock (clock),
      .we    (dye_we),
      .waddr (dye_waddr),
      .wdata (dye_wdata),
      .raddr (dye_raddr),
      .rdata (dye_rdata)
   );

   // Field being built by an advect pass
   pda_ram #(.WIDTH(8), .DEPTH(FIELD_CELLS)) u_next_ram (
      .clock (clock),
      .we    (nxt_we),
      .waddr (nxt_waddr),
      .wdata (nxt_wdata),
      .raddr (nxt_raddr),
      .rdata (nxt_rdata)
   );

   // Shared row divider
   pda_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .rsp      (div_rsp)
   );

   // The dye memory is never written while commands are being taken
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !dye_we)
      else $error("dye memory written while idle");

   // A divider result only turns up while the controller waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV_OM || state_ff == S_DIV_DR))
      else $error("divider result with nobody waiting");

   // A response beat is only raised from the finish step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside finish");

   // Copy-back write trails the read counter
   assert property (@(posedge clock) disable iff (reset)
      cpv_ff |-> ({1'b0, cpa_ff} < cp_ff))
      else $error("copy write ahead of read");

endmodule

### tb/tb_polar_dye_advection.sv
// Self-checking testbench for polar_dye_advection: stream driver, response
// monitor, watchdog and a behavioural model of the polar dye field.
// Depends on pda_pkg and the polar_dye_advection RTL.
`timescale 1ns / 1ps

module tb_polar_dye_advection;
   import pda_pkg::*;

   // One command beat, first field in the lowest bits
   typedef struct packed {
      logic [7:0]  dye_value;
      logic [6:0]  radius_index;
      logic [7:0]  angle_index;
      logic [6:0]  core_radius;
      logic [9:0]  outward_rate;
      logic [10:0] core_rate;
      logic [1:0]  cmd;
   } dye_cmd_type;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         STALL_LIMIT = 1500000;

   logic        clock;
   logic        reset;
   logic [55:0] req_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [8:0]  csr_wdata;

   // Model state: the flat field, its scratch copy and the registers
   logic [7:0]  dye_cells [FIELD_CELLS];
   logic [7:0]  swept_cells [FIELD_CELLS];
   int unsigned model_angles, model_radii, model_fade;

   dye_cmd_type pending_cmds [$];
   logic [7:0]  expected_cells [$];
   dye_cmd_type offered_cmd;
   int          send_gap, hold_cycles, idle_cycles, fail_count;
   bit          burst_mode, long_hold;

   polar_dye_advection u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Active grid size after clamping
   function automatic int grid_angles();
      if (model_angles < MIN_ANGLE_CELLS) return MIN_ANGLE_CELLS;
      if (model_angles > MAX_ANGLE_CELLS) return MAX_ANGLE_CELLS;
      return model_angles;
   endfunction

   function automatic int grid_radii();
      if (model_radii < MIN_RADIUS_CELLS) return MIN_RADIUS_CELLS;
      if (model_radii > MAX_RADIUS_CELLS) return MAX_RADIUS_CELLS;
      return model_radii;
   endfunction

   // Arithmetic shift of a signed int floors
   function automatic int blend(input int lo, input int hi, input int frac);
      return lo + (((hi - lo) * frac) >>> FRAC_BITS);
   endfunction

   // One semi-Lagrangian pass over the active grid, then fade
   function automatic void sweep_field(input int unsigned w0, input int unsigned v0,
                                       input int unsigned rc);
      int          na, nr, aq, rq, a0, a1, r0, r1, af, rf, top, bot, v;
      int unsigned om, vr;
      na = grid_angles();
      nr = grid_radii();
      for (int r = 0; r < nr; r++) begin
         om = (r <= rc) ? w0 : (w0 * rc * rc) / (r * r);
         vr = (v0 * (rc + 1)) / (r + rc + 1);
         rq = (r << FRAC_BITS) - int'(vr);
         for (int a = 0; a < na; a++) begin
            aq = (a << FRAC_BITS) - int'(om);
            a0 = aq >>> FRAC_BITS;
            r0 = rq >>> FRAC_BITS;
            af = aq - (a0 << FRAC_BITS);
            rf = rq - (r0 << FRAC_BITS);
            a1 = ((a0 + 1) % na + na) % na;
            a0 = (a0 % na + na) % na;
            r1 = r0 + 1;
            r0 = (r0 < 0) ? 0 : (r0 > nr - 1) ? nr - 1 : r0;
            r1 = (r1 < 0) ? 0 : (r1 > nr - 1) ? nr - 1 : r1;
            top = blend(dye_cells[r0*na+a0], dye_cells[r0*na+a1], af);
            bot = blend(dye_cells[r1*na+a0], dye_cells[r1*na+a1], af);
            v = blend(top, bot, rf);
            v = (v < 0) ? 0 : (v > 255) ? 255 : v;
            v = (v > int'(model_fade)) ? v - int'(model_fade) : 0;
            swept_cells[r*na+a] = v[7:0];
         end
      end
      for (int i = 0; i < na * nr; i++) dye_cells[i] = swept_cells[i];
   endfunction

   // Apply one command to the model and queue the response it gives
   function automatic void apply_cmd(input dye_cmd_type c);
      int         na, nr, idx;
      bit         in_grid;
      logic [7:0] rd_value;
      na = grid_angles();
      nr = grid_radii();
      in_grid = (c.angle_index < na) && (c.radius_index < nr);
      idx = c.radius_index * na + c.angle_index;
      rd_value = 8'd0;
      case (c.cmd)
         CMD_ADVECT: sweep_field(c.core_rate, c.outward_rate, c.core_radius);
         CMD_INJECT: begin
            if (in_grid && c.dye_value > dye_cells[idx]) dye_cells[idx] = c.dye_value;
         end
         CMD_READ: begin
            if (in_grid) rd_value = dye_cells[idx];
         end
         default: ;
      endcase
      expected_cells.push_back(rd_value);
   endfunction

   // Mostly short gaps, a few long ones, none in burst phases
   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (burst_mode || p < 45) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Command driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) apply_cmd(offered_cmd);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               offered_cmd = pending_cmds.pop_front();
               req_tdata <= {3'b000, offered_cmd};
               req_tvalid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response side: random back-pressure, one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_cycles = 0;
      end else if (long_hold && hold_cycles == 0) begin
         hold_cycles = 400;
         long_hold <= 1'b0;
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= (hold_cycles == 0);
      end else if (burst_mode) begin
         rsp_tready <= 1'b1;
      end else begin
         hold_cycles = ($urandom_range(99) < 5) ? $urandom_range(30, 8)
                                                 : ($urandom_range(99) < 35);
         rsp_tready <= (hold_cycles == 0);
      end
   end

   // Response check and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_cells.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual cell_value %0d",
                        $time, rsp_tdata);
               fail_count++;
            end else if (rsp_tdata !== expected_cells[0]) begin
               $display("%0t: cell_value mismatch, expected %0d, actual %0d",
                        $time, expected_cells[0], rsp_tdata);
               fail_count++;
               void'(expected_cells.pop_front());
            end else begin
               void'(expected_cells.pop_front());
            end
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("FAIL polar_dye_advection");
            $finish;
         end
      end
   end

   function automatic dye_cmd_type make_cmd(input logic [1:0] op, input int ai, input int ri,
                                            input int dv, input int w0, input int v0,
                                            input int rc);
      dye_cmd_type c;
      c.cmd = op;
      c.angle_index = 8'(ai);
      c.radius_index = 7'(ri);
      c.dye_value = 8'(dv);
      c.core_rate = 11'(w0);
      c.outward_rate = 10'(v0);
      c.core_radius = 7'(rc);
      return c;
   endfunction

   task automatic send(input dye_cmd_type c);
      pending_cmds.push_back(c);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_cmds.size() > 0 || req_tvalid || expected_cells.size() > 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 9'(value);
      case (idx)
         REG_ANGLE_CELLS:  model_angles = value & 9'h1FF;
         REG_RADIUS_CELLS: model_radii = value & 8'hFF;
         REG_FADE_STEP:    model_fade = value & 8'hFF;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Random command with content well spread; addresses mostly in the grid
   function automatic dye_cmd_type random_cmd();
      dye_cmd_type c;
      int          p;
      c = dye_cmd_type'(53'({$urandom, $urandom}));
      p = $urandom_range(99);
      c.cmd = (p < 45) ? CMD_INJECT : (p < 85) ? CMD_READ : (p < 95) ? CMD_ADVECT
                                                                     : CMD_UNUSED;
      if ($urandom_range(99) < 85) begin
         c.angle_index = 8'($urandom_range(grid_angles() - 1));
         c.radius_index = 7'($urandom_range(grid_radii() - 1));
      end
      if ($urandom_range(99) < 60) c.core_radius = 7'($urandom_range(grid_radii()));
      return c;
   endfunction

   // Stimulus and end of run
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_ANGLE_CELLS;
      csr_wdata = '0;
      burst_mode = 1'b0;
      long_hold = 1'b0;
      fail_count = 0;
      model_angles = ANGLE_CELLS_RST;
      model_radii = RADIUS_CELLS_RST;
      model_fade = FADE_STEP_RST;
      for (int i = 0; i < FIELD_CELLS; i++) dye_cells[i] = 8'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Full-size grid: corners, max keeps the larger, one full sweep
      send(make_cmd(CMD_INJECT, 0, 0, 255, 0, 0, 1));
      send(make_cmd(CMD_INJECT, 255, 127, 200, 0, 0, 1));
      send(make_cmd(CMD_INJECT, 5, 3, 100, 0, 0, 1));
      send(make_cmd(CMD_INJECT, 5, 3, 50, 0, 0, 1));
      send(make_cmd(CMD_INJECT, 6, 3, 0, 0, 0, 1));
      send(make_cmd(CMD_READ, 5, 3, 0, 0, 0, 1));
      send(make_cmd(CMD_UNUSED, 0, 0, 255, 2047, 1023, 127));
      send(make_cmd(CMD_ADVECT, 0, 0, 0, 300, 100, 5));
      send(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 1));
      send(make_cmd(CMD_READ, 255, 127, 0, 0, 0, 1));
      drain();

      // Smallest grid, no fade; extreme rates, zero and largest core
      write_reg(REG_ANGLE_CELLS, MIN_ANGLE_CELLS);
      write_reg(REG_RADIUS_CELLS, MIN_RADIUS_CELLS);
      write_reg(REG_FADE_STEP, 0);
      send(make_cmd(CMD_INJECT, 7, 3, 255, 0, 0, 1));
      send(make_cmd(CMD_INJECT, 8, 0, 99, 0, 0, 1));
      send(make_cmd(CMD_READ, 8, 0, 0, 0, 0, 1));
      send(make_cmd(CMD_ADVECT, 0, 0, 0, 2047, 1023, 0));
      send(make_cmd(CMD_READ, 7, 3, 0, 0, 0, 1));
      send(make_cmd(CMD_ADVECT, 0, 0, 0, 2047, 1023, 127));
      send(make_cmd(CMD_ADVECT, 0, 0, 0, 0, 0, 1));
      send(make_cmd(CMD_READ, 0, 127, 0, 0, 0, 1));
      drain();

      // Out-of-range sizes clamp; heaviest fade
      write_reg(REG_ANGLE_CELLS, 511);
      write_reg(REG_RADIUS_CELLS, 255);
      write_reg(REG_FADE_STEP, 255);
      send(make_cmd(CMD_READ, 255, 127, 0, 0, 0, 1));
      send(make_cmd(CMD_READ, 7, 3, 0, 0, 0, 1));
      drain();
      write_reg(REG_ANGLE_CELLS, 0);
      write_reg(REG_RADIUS_CELLS, 0);
      drain();
      send(make_cmd(CMD_ADVECT, 0, 0, 0, 17, 3, 2));
      send(make_cmd(CMD_READ, 1, 1, 0, 0, 0, 1));
      drain();

      // Random phases at small grid sizes
      for (int phase = 0; phase < 4; phase++) begin
         write_reg(REG_ANGLE_CELLS, ($urandom_range(9) == 0) ? $urandom_range(7)
                                                               : $urandom_range(40, 8));
         write_reg(REG_RADIUS_CELLS, ($urandom_range(9) == 0) ? $urandom_range(3)
                                                                : $urandom_range(16, 4));
         write_reg(REG_FADE_STEP, ($urandom_range(3) == 0) ? $urandom_range(255)
                                                           : $urandom_range(6));
         burst_mode = (phase == 2);
         if (phase == 1) long_hold <= 1'b1;
         for (int n = 0; n < 25; n++) send(random_cmd());
         drain();
      end

      if (fail_count == 0) begin
         $display("PASS polar_dye_advection");
      end else begin
         $display("FAIL polar_dye_advection");
      end
      $finish;
   end

endmodule
